[design/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SSP_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SSP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/ssp_pkg.sv]
// Package with widths, character codes and types of the size string parser.
`timescale 1ns / 1ps
package ssp_pkg;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned SIZE_W = 31;
  // holds max_size * 10 + 9 for any 31-bit max_size
  localparam int unsigned ACC_W  = 35;

  localparam logic [SIZE_W-1:0] MAX_SIZE_RST = 31'd1073741824;

  // character codes
  localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
  localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CH_W-1:0] CH_UP_A    = 8'h41;
  localparam logic [CH_W-1:0] CH_UP_Z    = 8'h5A;
  localparam logic [CH_W-1:0] CH_CASE    = 8'h20;
  localparam logic [CH_W-1:0] CH_LOW_B   = 8'h62;
  localparam logic [CH_W-1:0] CH_LOW_G   = 8'h67;
  localparam logic [CH_W-1:0] CH_LOW_I   = 8'h69;
  localparam logic [CH_W-1:0] CH_LOW_K   = 8'h6B;
  localparam logic [CH_W-1:0] CH_LOW_M   = 8'h6D;

  // result status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_NAS = 1'b1;

  // suffix scale codes (factor 1024^k)
  localparam logic [1:0] SCALE_NONE = 2'd0;
  localparam logic [1:0] SCALE_K    = 2'd1;
  localparam logic [1:0] SCALE_M    = 2'd2;
  localparam logic [1:0] SCALE_G    = 2'd3;

  typedef struct packed {
    logic [SIZE_W-1:0] size_value;
    logic              status;
  } rslt_t;

endpackage

[design/ssp_intf.sv]
// Handshake interfaces for the character, result and configuration channels.
`timescale 1ns / 1ps
interface ssp_ch_if import ssp_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface ssp_res_if import ssp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] size_value;
  logic              status;

  modport source (output valid, output size_value, output status, input ready);
  modport sink   (input valid, input size_value, input status, output ready);
endinterface

interface ssp_cfg_if import ssp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] max_size;

  modport source (output valid, output max_size, input ready);
  modport sink   (input valid, input max_size, output ready);
endinterface

[design/size_string_parser.sv]
// Size string parser: top level with input stage, parse state and result buffer.
`timescale 1ns / 1ps
// Usage:
//   ch_i  : one character per beat; a NUL character ends the string.
//   res_o : one beat per NUL, carrying size_value and status (0 ok,
//           1 not_a_size, size_value then zero).
//   cfg_i : writes max_size; always ready, write only while idle.
// Timing:
//   A character beat is registered, then parsed against the state when the
//   input stage advances; the result of a NUL beat is registered in the buffer.
//   One character per cycle is taken back to back unless a NUL stalls on a full buffer.
// Stalls:
//   Results go through a two-entry buffer (output register plus skid), so
//   non-NUL characters keep flowing while a result waits. Input stops only
//   when both entries are full and a NUL is next.
// Reset:
//   Clears the parse state and both result entries, and sets max_size
//   to 1073741824.
module size_string_parser import ssp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  ssp_ch_if.sink   ch_i,
  ssp_res_if.source res_o,
  ssp_cfg_if.sink  cfg_i
);

  typedef enum logic [2:0] {
    PH_FIRST,
    PH_DIGITS,
    PH_AFTER,
    PH_GOT_I,
    PH_DONE
  } phase_e;

  logic [SIZE_W-1:0] max_size_q;

  logic            s1_valid_q;
  logic [CH_W-1:0] s1_ch_q;

  phase_e             phase_q, phase_d;
  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [1:0]         scale_q, scale_d;
  logic               failed_q, failed_d;

  logic  out_valid_q, skid_valid_q;
  rslt_t out_q, skid_q;
  rslt_t res_d;

  logic            s1_nul, adv, push, pop, in_acc;
  logic            is_dig;
  logic [CH_W-1:0] lc;
  logic [3:0]      dig;
  logic [ACC_W-1:0] acc_x10;
  logic [SIZE_W-1:0] limit;
  logic [SIZE_W-1:0] scaled;
  logic            ok;

  // Handshakes
  assign s1_nul      = (s1_ch_q == CH_NUL);
  assign adv         = s1_valid_q && (!s1_nul || !skid_valid_q);
  assign push        = adv && s1_nul;
  assign pop         = out_valid_q && res_o.ready;
  assign ch_i.ready  = !s1_valid_q || adv;
  assign in_acc      = ch_i.valid && ch_i.ready;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid      = out_valid_q;
  assign res_o.size_value = out_q.size_value;
  assign res_o.status     = out_q.status;

  // Classify the staged character
  assign is_dig  = (s1_ch_q >= CH_ZERO) && (s1_ch_q <= CH_NINE);
  assign lc      = ((s1_ch_q >= CH_UP_A) && (s1_ch_q <= CH_UP_Z)) ? s1_ch_q + CH_CASE
                                                                   : s1_ch_q;
  assign dig     = s1_ch_q[3:0];
  assign acc_x10 = {acc_q[ACC_W-4:0], 3'b000} + {acc_q[ACC_W-2:0], 1'b0};

  // Scale the limit and the value by the suffix
  always_comb begin
    case (scale_q)
      SCALE_NONE: begin
        limit  = max_size_q;
        scaled = acc_q[SIZE_W-1:0];
      end
      SCALE_K: begin
        limit  = {10'd0, max_size_q[SIZE_W-1:10]};
        scaled = {acc_q[SIZE_W-11:0], 10'd0};
      end
      SCALE_M: begin
        limit  = {20'd0, max_size_q[SIZE_W-1:20]};
        scaled = {acc_q[SIZE_W-21:0], 20'd0};
      end
      default: begin
        limit  = {30'd0, max_size_q[SIZE_W-1:30]};
        scaled = {acc_q[0], 30'd0};
      end
    endcase
  end

  assign ok = !failed_q
           && ((phase_q == PH_DIGITS) || (phase_q == PH_AFTER) || (phase_q == PH_DONE))
           && (acc_q != '0)
           && (acc_q <= {{(ACC_W-SIZE_W){1'b0}}, limit});

  always_comb begin
    res_d.size_value = ok ? scaled : '0;
    res_d.status     = ok ? STATUS_OK : STATUS_NAS;
  end

  // Advance the parse state by one character
  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    scale_d  = scale_q;
    failed_d = failed_q;
    if (s1_nul) begin
      phase_d  = PH_FIRST;
      acc_d    = '0;
      scale_d  = SCALE_NONE;
      failed_d = 1'b0;
    end else if (!failed_q) begin
      case (phase_q)
        PH_FIRST: begin
          if (is_dig) begin
            acc_d   = {{(ACC_W-4){1'b0}}, dig};
            phase_d = PH_DIGITS;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_DIGITS: begin
          if (is_dig) begin
            if (acc_q > {{(ACC_W-SIZE_W){1'b0}}, max_size_q}) begin
              failed_d = 1'b1;
            end else begin
              acc_d = acc_x10 + {{(ACC_W-4){1'b0}}, dig};
            end
          end else begin
            phase_d = PH_AFTER;
            if (lc == CH_LOW_K) begin
              scale_d = SCALE_K;
            end else if (lc == CH_LOW_M) begin
              scale_d = SCALE_M;
            end else if (lc == CH_LOW_G) begin
              scale_d = SCALE_G;
            end else if (lc == CH_LOW_B) begin
              phase_d = PH_DONE;
            end else if (lc == CH_LOW_I) begin
              phase_d = PH_GOT_I;
            end else begin
              failed_d = 1'b1;
            end
          end
        end
        PH_AFTER: begin
          if (lc == CH_LOW_B) begin
            phase_d = PH_DONE;
          end else if (lc == CH_LOW_I) begin
            phase_d = PH_GOT_I;
          end else begin
            failed_d = 1'b1;
          end
        end
        PH_GOT_I: begin
          if (lc == CH_LOW_B) begin
            phase_d = PH_DONE;
          end else begin
            failed_d = 1'b1;
          end
        end
        default: begin
          failed_d = 1'b1;
        end
      endcase
    end
  end

  // Hold configuration, staged character, parse state and result buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_size_q   <= MAX_SIZE_RST;
      s1_valid_q   <= 1'b0;
      s1_ch_q      <= '0;
      phase_q      <= PH_FIRST;
      acc_q        <= '0;
      scale_q      <= SCALE_NONE;
      failed_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else begin
      if (cfg_i.valid) begin
        max_size_q <= cfg_i.max_size;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        s1_ch_q    <= ch_i.ch;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        phase_q  <= phase_d;
        acc_q    <= acc_d;
        scale_q  <= scale_d;
        failed_q <= failed_d;
      end
      // result buffer: refill the output register, spill into skid
      if (!out_valid_q || pop) begin
        out_valid_q  <= skid_valid_q || push;
        skid_valid_q <= 1'b0;
        out_q        <= skid_valid_q ? skid_q : res_d;
      end else if (push) begin
        skid_valid_q <= 1'b1;
        skid_q       <= res_d;
      end
    end
  end

endmodule

[design/ssp_checker.sv]
// Port-level checker for the size string parser, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssp_checker import ssp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              ch_valid_i,
  input logic              ch_ready_i,
  input logic [CH_W-1:0]   ch_i,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [SIZE_W-1:0] size_value_i,
  input logic              status_i
);

  // A stalled result beat holds its payload
  `SSP_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(size_value_i) && $stable(status_i), "result changed while stalled")

  // An ok result carries a nonzero size
  `SSP_ASSERT_IMPL(a_ok_nonzero, clk_i, rst_ni, res_valid_i && (status_i == STATUS_OK), size_value_i != '0, "ok result with zero size")

  // A rejected string reports size zero
  `SSP_ASSERT_IMPL(a_nas_zero, clk_i, rst_ni, res_valid_i && (status_i == STATUS_NAS), size_value_i == '0, "not_a_size result with nonzero size")

  // A result that appears on an empty output comes from an accepted NUL beat
  `SSP_ASSERT_IMPL(a_res_from_nul, clk_i, rst_ni, $rose(res_valid_i), $past(ch_valid_i && ch_ready_i && (ch_i == CH_NUL), 2), "result without a NUL beat")

endmodule

bind size_string_parser ssp_checker u_ssp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .ch_valid_i   (ch_i.valid),
  .ch_ready_i   (ch_i.ready),
  .ch_i         (ch_i.ch),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .size_value_i (res_o.size_value),
  .status_i     (res_o.status)
);
